// ===== rtl/lwbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Longest window of bounded spread: shared package
// Types and constants that the controller, the datapath and the top level use.
// ----------------------------------------------------------------------------
package lwbs_pkg;

	localparam int unsigned VALUE_W   = 32;
	localparam int unsigned LEN_OUT_W = 11;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP_RD,
		ST_POP_CMP,
		ST_PUSH,
		ST_SHR_RD,
		ST_SHR_CMP,
		ST_FIN
	} lwbs_state_t;

	typedef struct packed {
		logic take;
		logic rd_tail;
		logic pop_eval;
		logic push;
		logic shr_eval;
		logic finish;
	} lwbs_cmd_t;

	typedef struct packed {
		logic full;
		logic pop_any;
		logic shr_pop;
		logic out_free;
	} lwbs_status_t;

endpackage

// ===== rtl/lwbs_if.sv =====
// ----------------------------------------------------------------------------
// Longest window of bounded spread: channel interfaces
// Valid/ready channels for sample words, result words and the limit register.
// ----------------------------------------------------------------------------
interface lwbs_sample_if;
	logic                              valid;
	logic                              ready;
	logic [lwbs_pkg::VALUE_W-1:0]      sample_value;
	logic                              is_last;

	modport source (output valid, output sample_value, output is_last, input ready);
	modport sink (input valid, input sample_value, input is_last, output ready);
endinterface

interface lwbs_result_if;
	logic                              valid;
	logic                              ready;
	logic [lwbs_pkg::LEN_OUT_W-1:0]    best_length;
	logic                              sequence_done;
	logic                              overflow;

	modport source (output valid, output best_length, output sequence_done,
		output overflow, input ready);
	modport sink (input valid, input best_length, input sequence_done,
		input overflow, output ready);
endinterface

interface lwbs_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [lwbs_pkg::VALUE_W-1:0]      spread_limit;

	modport source (output valid, output spread_limit, input ready);
	modport sink (input valid, input spread_limit, output ready);
endinterface

// ===== rtl/lwbs_ram.sv =====
// ----------------------------------------------------------------------------
// Longest window of bounded spread: generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lwbs_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ===== rtl/lwbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// Longest window of bounded spread: controller
// Sequences tail pops, the push, head pops and the result hand-off per word.
// ----------------------------------------------------------------------------
module lwbs_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  lwbs_pkg::lwbs_status_t status,
	output lwbs_pkg::lwbs_cmd_t    cmd
);

	lwbs_pkg::lwbs_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lwbs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lwbs_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = status.full ? lwbs_pkg::ST_FIN : lwbs_pkg::ST_POP_RD;
				end
			end
			lwbs_pkg::ST_POP_RD: begin
				state_d = lwbs_pkg::ST_POP_CMP;
			end
			lwbs_pkg::ST_POP_CMP: begin
				state_d = status.pop_any ? lwbs_pkg::ST_POP_RD : lwbs_pkg::ST_PUSH;
			end
			lwbs_pkg::ST_PUSH: begin
				state_d = lwbs_pkg::ST_SHR_RD;
			end
			lwbs_pkg::ST_SHR_RD: begin
				state_d = lwbs_pkg::ST_SHR_CMP;
			end
			lwbs_pkg::ST_SHR_CMP: begin
				state_d = status.shr_pop ? lwbs_pkg::ST_SHR_RD : lwbs_pkg::ST_FIN;
			end
			lwbs_pkg::ST_FIN: begin
				if (status.out_free) begin
					state_d = lwbs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lwbs_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			lwbs_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			lwbs_pkg::ST_POP_RD: begin
				cmd.rd_tail = 1'b1;
			end
			lwbs_pkg::ST_POP_CMP: begin
				cmd.pop_eval = 1'b1;
			end
			lwbs_pkg::ST_PUSH: begin
				cmd.push = 1'b1;
			end
			lwbs_pkg::ST_SHR_RD: begin
				cmd.rd_tail = 1'b0;
			end
			lwbs_pkg::ST_SHR_CMP: begin
				cmd.shr_eval = 1'b1;
			end
			lwbs_pkg::ST_FIN: begin
				cmd.finish = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ===== rtl/lwbs_dp.sv =====
// ----------------------------------------------------------------------------
// Longest window of bounded spread: datapath
// Deque storage and pointers, window bound, best length and the result register.
// ----------------------------------------------------------------------------
module lwbs_dp #(
	parameter int unsigned MAX_LEN = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lwbs_pkg::lwbs_cmd_t                cmd,
	output lwbs_pkg::lwbs_status_t             status,
	input  logic [lwbs_pkg::VALUE_W-1:0]       sample_value,
	input  logic                               is_last,
	input  logic                               cfg_we,
	input  logic [lwbs_pkg::VALUE_W-1:0]       cfg_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [lwbs_pkg::LEN_OUT_W-1:0]     best_length,
	output logic                               sequence_done,
	output logic                               overflow
);

	localparam int unsigned VW = lwbs_pkg::VALUE_W;
	localparam int unsigned AW = $clog2(MAX_LEN);
	localparam int unsigned CW = $clog2(MAX_LEN + 1);
	localparam int unsigned PW = $clog2(MAX_LEN + 2);
	localparam int unsigned EW = PW + VW;

	logic [VW-1:0] limit_q;
	logic [VW-1:0] v_q;
	logic          last_q;
	logic          over_q;
	logic [PW-1:0] pos_q;
	logic [PW-1:0] wl_q;
	logic [PW-1:0] best_q;
	logic [CW-1:0] min_head_q, min_tail_q, max_head_q, max_tail_q;
	logic          out_valid_q;

	logic [CW-1:0] min_rd_idx, max_rd_idx;
	logic [EW-1:0] min_rd_data, max_rd_data, wr_entry;
	logic [VW-1:0] min_val, max_val;
	logic [PW-1:0] min_pos, max_pos;
	logic          min_pop, max_pop;
	logic          shr_pop, older_min;
	logic [PW-1:0] dropped, dropped_next;
	logic [PW-1:0] win_len, best_new;

	assign min_rd_idx = cmd.rd_tail ? (min_tail_q - CW'(1)) : min_head_q;
	assign max_rd_idx = cmd.rd_tail ? (max_tail_q - CW'(1)) : max_head_q;
	assign wr_entry   = {pos_q, v_q};

	lwbs_ram #(.WIDTH(EW), .DEPTH(MAX_LEN)) u_min_ram (
		.clk     (clk),
		.wr_en   (cmd.push),
		.wr_addr (min_tail_q[AW-1:0]),
		.wr_data (wr_entry),
		.rd_addr (min_rd_idx[AW-1:0]),
		.rd_data (min_rd_data)
	);

	lwbs_ram #(.WIDTH(EW), .DEPTH(MAX_LEN)) u_max_ram (
		.clk     (clk),
		.wr_en   (cmd.push),
		.wr_addr (max_tail_q[AW-1:0]),
		.wr_data (wr_entry),
		.rd_addr (max_rd_idx[AW-1:0]),
		.rd_data (max_rd_data)
	);

	assign min_val = min_rd_data[VW-1:0];
	assign min_pos = min_rd_data[EW-1:VW];
	assign max_val = max_rd_data[VW-1:0];
	assign max_pos = max_rd_data[EW-1:VW];

	assign min_pop = (min_tail_q > min_head_q) && (min_val >= v_q);
	assign max_pop = (max_tail_q > max_head_q) && (max_val <= v_q);

	assign shr_pop = (min_tail_q > min_head_q) && (max_tail_q > max_head_q) &&
		(max_val >= min_val) && ((max_val - min_val) > limit_q);
	assign older_min    = min_pos < max_pos;
	assign dropped      = older_min ? min_pos : max_pos;
	assign dropped_next = dropped + PW'(1);

	assign win_len  = (pos_q >= wl_q) ? (pos_q - wl_q + PW'(1)) : '0;
	assign best_new = (!over_q && (win_len > best_q)) ? win_len : best_q;

	assign status.full     = pos_q >= PW'(MAX_LEN);
	assign status.pop_any  = min_pop || max_pop;
	assign status.shr_pop  = shr_pop;
	assign status.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
		end else if (cfg_we) begin
			limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			v_q    <= sample_value;
			last_q <= is_last;
			over_q <= status.full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			wl_q       <= PW'(1);
			best_q     <= '0;
			min_head_q <= '0;
			min_tail_q <= '0;
			max_head_q <= '0;
			max_tail_q <= '0;
		end else begin
			if (cmd.take && !status.full) begin
				pos_q <= pos_q + PW'(1);
			end
			if (cmd.pop_eval) begin
				if (min_pop) begin
					min_tail_q <= min_tail_q - CW'(1);
				end
				if (max_pop) begin
					max_tail_q <= max_tail_q - CW'(1);
				end
			end
			if (cmd.push) begin
				min_tail_q <= min_tail_q + CW'(1);
				max_tail_q <= max_tail_q + CW'(1);
			end
			if (cmd.shr_eval && shr_pop) begin
				if (older_min) begin
					min_head_q <= min_head_q + CW'(1);
				end else begin
					max_head_q <= max_head_q + CW'(1);
				end
				if (dropped_next > wl_q) begin
					wl_q <= dropped_next;
				end
			end
			if (cmd.finish) begin
				if (last_q) begin
					pos_q      <= '0;
					wl_q       <= PW'(1);
					best_q     <= '0;
					min_head_q <= '0;
					min_tail_q <= '0;
					max_head_q <= '0;
					max_tail_q <= '0;
				end else begin
					best_q <= best_new;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			best_length   <= lwbs_pkg::LEN_OUT_W'(best_new);
			sequence_done <= last_q;
			overflow      <= over_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/longest_window_bounded_spread_unit.sv =====
// ----------------------------------------------------------------------------
// Longest window of bounded spread: top level
// For each sample word, returns the longest window so far whose max minus min
// stays within the configured limit, using a minimum and a maximum deque.
// ----------------------------------------------------------------------------
// Each sample word yields one result word. After acceptance a word passes
// through rounds of tail pops (a read and a compare), the push, rounds of
// head pops that shrink the window (a read and a compare) and the result
// hand-off; the read and compare steps are set by the single registered read
// port of each deque memory, which the controller visits once per comparison
// round. Pops are amortized. A word that arrives after MAX_LEN words of its
// sequence is flagged as overflow and goes straight to the result hand-off.
// The next sample word is taken while a finished result still waits.
// The spread limit may only be written while the unit is idle.
module longest_window_bounded_spread_unit #(
	parameter int unsigned MAX_LEN = 1024
) (
	input logic         clk,
	input logic         arst_n,
	lwbs_sample_if.sink sample,
	lwbs_result_if.source result,
	lwbs_cfg_if.sink    setup
);

	lwbs_pkg::lwbs_cmd_t    cmd;
	lwbs_pkg::lwbs_status_t status;
	logic                   in_ready;

	assign sample.ready = in_ready;
	assign setup.ready  = 1'b1;

	lwbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	lwbs_dp #(.MAX_LEN(MAX_LEN)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.sample_value  (sample.sample_value),
		.is_last       (sample.is_last),
		.cfg_we        (setup.valid),
		.cfg_data      (setup.spread_limit),
		.out_valid     (result.valid),
		.out_ready     (result.ready),
		.best_length   (result.best_length),
		.sequence_done (result.sequence_done),
		.overflow      (result.overflow)
	);

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.take, cmd.pop_eval, cmd.push, cmd.shr_eval, cmd.finish}))
		else $error("More than one datapath command in a cycle.");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!result.valid || result.ready))
		else $error("Result register loaded while an untaken word is held.");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(cmd.finish))
		else $error("Result word appeared without a finish command.");

	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |-> !result.valid || !cmd.finish)
		else $error("Sample word taken while a result was being loaded.");

endmodule
